FILE: rtl/core/bpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_pkg
// Shared types, codes and helpers for the bitmap position list.
// ----------------------------------------------------------------------------
package bpl_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_NEXT   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_REWIND = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ADD_CALC,
    S_ADD_RD,
    S_ADD_WR,
    S_NEXT_START,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EMIT_LZ,
    S_EMIT_POS,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic do_clear;
    logic do_rewind;
    logic add_calc;
    logic add_rd;
    logic add_wr;
    logic start_cursor;
    logic scan_rd;
    logic scan_step;
    logic load_bits;
    logic emit_lz;
    logic emit;
    logic sweep;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic add_ok;
    logic past_end;
    logic empty;
    logic bits_zero;
    logic word_zero;
    logic at_last;
    logic sweep_last;
    logic out_busy;
  } stat_t;

  localparam logic [31:0] WORD_MSB  = 32'h8000_0000;
  localparam int          WORD_BITS = 32;
  localparam int          COUNT_W   = 14;

  // Offset of the highest set bit counted from the MSB; w must be nonzero.
  function automatic logic [4:0] lead_zeros(input logic [31:0] w);
    logic [31:0] v;
    logic [4:0]  n;
    v = w;
    n = 5'd0;
    if (v[31:16] == 16'd0) begin n[4] = 1'b1; v = {v[15:0], 16'd0}; end
    if (v[31:24] == 8'd0)  begin n[3] = 1'b1; v = {v[23:0], 8'd0};  end
    if (v[31:28] == 4'd0)  begin n[2] = 1'b1; v = {v[27:0], 4'd0};  end
    if (v[31:30] == 2'd0)  begin n[1] = 1'b1; v = {v[29:0], 2'd0};  end
    if (v[31] == 1'b0)     begin n[0] = 1'b1; end
    return n;
  endfunction

endpackage

FILE: rtl/core/bpl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bpl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: rtl/core/bpl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_ctrl
// Sequencer for add, next, clear and rewind operations.
// ----------------------------------------------------------------------------
module bpl_ctrl
  import bpl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state, state_next;
  op_t    op;

  assign op = op_t'(opcode);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (op)
            OP_ADD:  state_next = S_ADD_CALC;
            OP_NEXT: state_next = S_NEXT_START;
            OP_CLEAR: begin
              cmd.do_clear = 1'b1;
              state_next   = S_CLEAR;
            end
            OP_REWIND: begin
              cmd.do_rewind = 1'b1;
              state_next    = S_DONE;
            end
          endcase
        end
      end
      S_ADD_CALC: begin
        cmd.add_calc = 1'b1;
        state_next   = S_ADD_RD;
      end
      S_ADD_RD: begin
        cmd.add_rd = 1'b1;
        state_next = stat.add_ok ? S_ADD_WR : S_DONE;
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_next = S_DONE;
      end
      S_NEXT_START: begin
        if (stat.past_end) begin
          cmd.do_rewind = 1'b1;
          state_next    = S_DONE;
        end else if (stat.empty) begin
          state_next = S_DONE;
        end else begin
          cmd.start_cursor = 1'b1;
          state_next       = stat.bits_zero ? S_SCAN_RD : S_EMIT_LZ;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat.word_zero && !stat.at_last) begin
          cmd.scan_step = 1'b1;
          state_next    = S_SCAN_RD;
        end else if (stat.word_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.load_bits = 1'b1;
          state_next    = S_EMIT_LZ;
        end
      end
      S_EMIT_LZ: begin
        cmd.emit_lz = 1'b1;
        state_next  = S_EMIT_POS;
      end
      S_EMIT_POS: begin
        cmd.emit   = 1'b1;
        state_next = S_DONE;
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

FILE: rtl/core/bpl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_dp
// Bitmap store, read cursor, counters and output register.
// ----------------------------------------------------------------------------
module bpl_dp
  import bpl_pkg::*;
#(
  parameter int MAX_WORDS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [31:0]        position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               accepted,
  output logic               found,
  output logic [31:0]        next_position,
  output logic [COUNT_W-1:0] stored_count
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int IW = AW + 1;

  logic [31:0]        pos_r, base, bits, d_r, res_np;
  logic [IW-1:0]      last_w, read_w, hw;
  logic [AW-1:0]      clr_addr;
  logic [COUNT_W-1:0] count;
  logic               rej_r, res_acc, res_fnd;
  logic [4:0]         b_r;

  logic               ram_en, ram_we;
  logic [AW-1:0]      ram_addr;
  logic [31:0]        ram_wdata, ram_rdata;

  logic [AW-1:0]      add_addr, rd_addr;
  logic [IW-1:0]      add_word, rd_idx;
  logic [31:0]        d_calc, bits_after, pos_calc;
  logic               rej_calc, fits;

  assign add_addr   = d_r[5 +: AW];
  assign add_word   = {{(IW-AW){1'b0}}, add_addr} + IW'(1);
  assign rd_idx     = read_w - IW'(1);
  assign rd_addr    = rd_idx[AW-1:0];
  assign d_calc     = (base == 32'd0) ? 32'd0 : pos_r - base;
  assign rej_calc   = (pos_r == 32'd0) || ((base != 32'd0) && (pos_r <= base));
  assign fits       = {5'd0, d_r[31:5]} < 32'(MAX_WORDS);
  assign bits_after = bits & ~(WORD_MSB >> b_r);
  assign pos_calc   = base + 32'({rd_idx, b_r});

  assign stat.add_ok     = !rej_r && fits;
  assign stat.past_end   = read_w > last_w;
  assign stat.empty      = last_w == '0;
  assign stat.bits_zero  = (read_w == '0) || (bits == 32'd0);
  assign stat.word_zero  = ram_rdata == 32'd0;
  assign stat.at_last    = read_w >= last_w;
  assign stat.sweep_last = (hw == '0) || ({{(IW-AW){1'b0}}, clr_addr} == hw - IW'(1));
  assign stat.out_busy   = out_valid && out_stall;

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = 32'd0;
    if (cmd.sweep) begin
      ram_en   = hw != '0;
      ram_we   = 1'b1;
      ram_addr = clr_addr;
    end else if (cmd.add_rd && stat.add_ok) begin
      ram_en   = 1'b1;
      ram_addr = add_addr;
    end else if (cmd.add_wr) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = add_addr;
      ram_wdata = ram_rdata | (WORD_MSB >> d_r[4:0]);
    end else if (cmd.scan_rd) begin
      ram_en   = 1'b1;
      ram_addr = rd_addr;
    end
  end

  bpl_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_WORDS)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= 32'd0;
      last_w    <= '0;
      read_w    <= '0;
      bits      <= 32'd0;
      count     <= '0;
      hw        <= IW'(MAX_WORDS);
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.do_clear) begin
        base   <= 32'd0;
        last_w <= '0;
        read_w <= '0;
        bits   <= 32'd0;
        count  <= '0;
      end
      if (cmd.do_rewind) begin
        read_w <= '0;
        bits   <= 32'd0;
      end
      if (cmd.start_cursor && read_w == '0) begin
        read_w <= IW'(1);
        bits   <= 32'd0;
      end
      if (cmd.add_wr) begin
        if (base == 32'd0) base <= pos_r;
        last_w <= add_word;
        read_w <= add_word;
        bits   <= 32'd0;
        if (count != '1) count <= count + COUNT_W'(1);
        if (add_word > hw) hw <= add_word;
      end
      if (cmd.scan_step) read_w <= read_w + IW'(1);
      if (cmd.load_bits) bits <= ram_rdata;
      if (cmd.emit) begin
        bits <= bits_after;
        if (bits_after == 32'd0) read_w <= read_w + IW'(1);
      end
      if (cmd.sweep) begin
        if (stat.sweep_last) begin
          hw       <= '0;
          clr_addr <= '0;
        end else begin
          clr_addr <= clr_addr + AW'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_r   <= position;
      res_acc <= 1'b0;
      res_fnd <= 1'b0;
      res_np  <= 32'd0;
    end
    if (cmd.add_calc) begin
      d_r   <= d_calc;
      rej_r <= rej_calc;
    end
    if (cmd.add_wr) res_acc <= 1'b1;
    if (cmd.emit_lz) b_r <= lead_zeros(bits);
    if (cmd.emit) begin
      res_fnd <= 1'b1;
      res_np  <= pos_calc;
    end
    if (cmd.load_out) begin
      accepted      <= res_acc;
      found         <= res_fnd;
      next_position <= res_np;
      stored_count  <= count;
    end
  end

endmodule

FILE: rtl/core/bitmap_position_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_position_list
// Position list held as a bitmap of 32-bit words relative to a base position.
// ----------------------------------------------------------------------------
// One item is processed at a time and each gives one result. An add steps
// through calc, word read and word write, with no RAM access when it is
// rejected; rewind goes straight to the result. Clear sweeps every word up
// to the highest word written since the last clear. Next goes straight to
// emit when the cursor word still has pending bits, else scans on, one
// single-port RAM read per word, and on an empty or exhausted list gives no
// position. After reset the RAM is swept to zero, one word per cycle, all
// MAX_WORDS words before the first item is taken. The result register lets
// the next item be accepted while a result waits.
// ----------------------------------------------------------------------------
module bitmap_position_list
  import bpl_pkg::*;
#(
  parameter int MAX_WORDS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [31:0]        position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               accepted,
  output logic               found,
  output logic [31:0]        next_position,
  output logic [COUNT_W-1:0] stored_count
);

  cmd_t  cmd;
  stat_t stat;

  bpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpl_dp #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .position      (position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .accepted      (accepted),
    .found         (found),
    .next_position (next_position),
    .stored_count  (stored_count)
  );

endmodule
